// File: rtl/bellman_max_backup_assert.svh
// assertion macros shared by the checker
`ifndef BELLMAN_MAX_BACKUP_ASSERT_SVH
`define BELLMAN_MAX_BACKUP_ASSERT_SVH

// checked only out of reset
`define BMB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BMB_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/bmb_pkg.sv
package bmb_pkg;

    localparam int NUM_STATES = 128;

    localparam logic [16:0]        DISC_RESET = 17'd58982;
    localparam logic [16:0]        ONE_Q16    = 17'd65536;
    localparam logic signed [31:0] Q_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN      = 32'sh8000_0000;
    localparam logic [30:0]        CHANGE_MAX = 31'h7FFF_FFFF;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_ACTION = 1'b1;

    typedef struct packed {
        logic               func;
        logic [6:0]         state_index;
        logic [6:0]         next_state;
        logic signed [31:0] reward;
        logic signed [31:0] load_value;
        logic               last_action;
    } t_in_item;

    typedef struct packed {
        logic [6:0]         out_state;
        logic signed [31:0] new_value;
        logic [30:0]        change;
        logic [30:0]        max_change;
    } t_out_item;

    // classified item as queued between front and back
    typedef struct packed {
        logic               is_action;
        logic               last;
        logic               si_ok;
        logic               ns_ok;
        logic [6:0]         state_index;
        logic [6:0]         next_state;
        logic signed [31:0] reward;
        logic signed [31:0] load_value;
    } t_cmd;

endpackage

// File: rtl/bellman_max_backup.sv
// Bellman optimality backup, one sweep, Q16.16 values with a Q1.16 discount.
// Items enter a two-deep queue; a back-end sequencer executes them one at a
// time: a load writes the value table; an action reads the value table,
// does a 32x18 multiply, then an add with saturation and running max, and
// the last action of a state goes on to a final step that forms the change
// and the sup-norm and loads the output register. Discount writes above
// 65536 are stored as 65536. The value table is not cleared at reset:
// every successor and every state backed up must be loaded first.
module bellman_max_backup #(
    parameter int NUM_STATES = bmb_pkg::NUM_STATES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [16:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bmb_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bmb_pkg::t_out_item o_out_data
);

    logic [16:0]   r_gamma;
    logic          cmd_valid;
    logic          cmd_pop;
    bmb_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= bmb_pkg::DISC_RESET;
        end else if (i_cfg_we) begin
            r_gamma <= (i_cfg_wdata > bmb_pkg::ONE_Q16) ? bmb_pkg::ONE_Q16 : i_cfg_wdata;
        end
    end

    bmb_front #(
        .NUM_STATES (NUM_STATES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    bmb_back #(
        .NUM_STATES (NUM_STATES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gamma     (r_gamma),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/bmb_ram.sv
module bmb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = bmb_pkg::NUM_STATES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: rtl/bmb_front.sv
module bmb_front #(
    parameter int NUM_STATES = bmb_pkg::NUM_STATES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  bmb_pkg::t_in_item i_in_data,
    output logic             o_cmd_valid,
    output bmb_pkg::t_cmd    o_cmd,
    input  logic             i_cmd_pop
);

    bmb_pkg::t_cmd r_q [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_count;
    bmb_pkg::t_cmd n_cmd;
    logic          push;

    always_comb begin
        n_cmd.is_action   = (i_in_data.func == bmb_pkg::FUNC_ACTION);
        n_cmd.last        = i_in_data.last_action;
        n_cmd.si_ok       = (int'(i_in_data.state_index) < NUM_STATES);
        n_cmd.ns_ok       = (int'(i_in_data.next_state) < NUM_STATES);
        n_cmd.state_index = i_in_data.state_index;
        n_cmd.next_state  = i_in_data.next_state;
        n_cmd.reward      = i_in_data.reward;
        n_cmd.load_value  = i_in_data.load_value;
    end

    assign o_in_stall  = (r_count == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (i_cmd_pop) begin
                r_rptr <= !r_rptr;
            end
            unique case ({push, i_cmd_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= n_cmd;
        end
    end

endmodule

// File: rtl/bmb_back.sv
module bmb_back #(
    parameter int NUM_STATES = bmb_pkg::NUM_STATES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [16:0]       i_gamma,
    input  logic              i_cmd_valid,
    input  bmb_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bmb_pkg::t_out_item o_out_data
);

    localparam int AW = $clog2(NUM_STATES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    logic                r_last;
    logic [6:0]          r_si;
    logic                r_ns_ok;
    logic                r_si_ok;
    logic signed [31:0]  r_reward;
    logic signed [49:0]  r_prod;
    logic signed [31:0]  r_stored;
    logic signed [31:0]  r_best;
    logic signed [31:0]  n_best;
    logic [30:0]         r_sup;
    logic [30:0]         n_sup;
    logic                r_out_valid;
    bmb_pkg::t_out_item  r_out;

    logic          ram_we;
    logic [31:0]   rdata_a;
    logic [31:0]   rdata_b;

    logic signed [31:0] v_next;
    logic signed [17:0] g_s;
    logic signed [49:0] n_prod;
    logic signed [34:0] sum;
    logic signed [31:0] q;
    logic signed [33:0] diff;
    logic [33:0]        mag;
    logic [30:0]        chg;
    logic               out_free;
    logic               emit;

    bmb_ram #(
        .WIDTH (32),
        .DEPTH (NUM_STATES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (AW'(i_cmd.state_index)),
        .i_wdata   (i_cmd.load_value),
        .i_raddr_a (AW'(i_cmd.next_state)),
        .i_raddr_b (AW'(i_cmd.state_index)),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // multiply stage: out-of-range successors read as zero
    assign v_next = r_ns_ok ? signed'(rdata_a) : 32'sd0;
    assign g_s    = signed'({1'b0, i_gamma});
    assign n_prod = v_next * g_s;

    // add stage: floor shift then saturate
    assign sum = 35'(r_reward) + 35'(r_prod >>> 16);
    always_comb begin
        if (sum > 35'(bmb_pkg::Q_MAX)) begin
            q = bmb_pkg::Q_MAX;
        end else if (sum < 35'(bmb_pkg::Q_MIN)) begin
            q = bmb_pkg::Q_MIN;
        end else begin
            q = 32'(sum);
        end
    end

    // final stage: saturated magnitude of the change
    assign diff = 34'(r_best) - 34'(r_stored);
    assign mag  = diff[33] ? 34'(-diff) : 34'(diff);
    assign chg  = (mag > 34'(bmb_pkg::CHANGE_MAX)) ? bmb_pkg::CHANGE_MAX : mag[30:0];

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        n_best    = r_best;
        n_sup     = r_sup;
        o_cmd_pop = 1'b0;
        ram_we    = 1'b0;
        emit      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.is_action) begin
                        n_state = ST_MUL;
                    end else begin
                        ram_we = i_cmd.si_ok;
                        n_sup  = '0;
                    end
                end
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                if (q > r_best) begin
                    n_best = q;
                end
                n_state = r_last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_sup   = (chg > r_sup) ? chg : r_sup;
                    n_best  = bmb_pkg::Q_MIN;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_best      <= bmb_pkg::Q_MIN;
            r_sup       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_best  <= n_best;
            r_sup   <= n_sup;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_last   <= i_cmd.last;
            r_si     <= i_cmd.state_index;
            r_ns_ok  <= i_cmd.ns_ok;
            r_si_ok  <= i_cmd.si_ok;
            r_reward <= i_cmd.reward;
        end
        if (r_state == ST_MUL) begin
            r_prod   <= n_prod;
            r_stored <= r_si_ok ? signed'(rdata_b) : 32'sd0;
        end
        if (emit) begin
            r_out.out_state  <= r_si;
            r_out.new_value  <= r_best;
            r_out.change     <= chg;
            r_out.max_change <= n_sup;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/bmb_checker.sv
`include "bellman_max_backup_assert.svh"

module bmb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input bmb_pkg::t_out_item o_out_data
);

    // a stalled result stays put
    `BMB_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")
    `BMB_ASSERT(a_out_stable, o_out_valid && i_out_stall |=> $stable(o_out_data), "stalled result changed")
    // reset empties the output register
    `BMB_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid, "result present after reset")
    // the running sup-norm already includes this change
    `BMB_ASSERT(a_sup_bound, o_out_valid |-> o_out_data.change <= o_out_data.max_change, "change above sup-norm")
    // the queue only fills on an offered item
    `BMB_ASSERT(a_stall_cause, $rose(o_in_stall) |-> $past(i_in_valid), "input stall without an item")

endmodule

bind bellman_max_backup bmb_checker u_bmb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
